// ===== src/llba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llba_pkg
// Shared constants, payload types and helpers for the least-loaded bin
// assigner.
// ----------------------------------------------------------------------------
package llba_pkg;

  localparam int MAX_BINS   = 16;
  localparam int LOAD_WIDTH = 32;
  localparam int LEVELS     = $clog2(MAX_BINS);
  localparam int TREE_SIZE  = 1 << LEVELS;
  localparam int IDX_W      = LEVELS;
  localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ACTIVE_W   = 5;
  localparam int BIN_W      = 5;
  localparam int SIZE_W     = 16;

  localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET = ACTIVE_W'(16);
  localparam logic [LOAD_WIDTH-1:0] LOAD_MAX     = {LOAD_WIDTH{1'b1}};
  localparam logic [LVL_W-1:0]      LAST_LEVEL   = LVL_W'(LEVELS - 1);

  typedef logic [LOAD_WIDTH-1:0] load_t;
  typedef logic [IDX_W-1:0]      bin_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] job_size;
    logic              new_batch;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_number;
    logic             load_saturated;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic reduce;
    logic update;
  } ctl_cmd_t;

  function automatic logic [BIN_W-1:0] bin_num(input bin_idx_t idx);
    logic [31:0] t;
    t = 32'(idx) + 32'd1;
    return t[BIN_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/llba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llba_ctrl
// Sequencer: accepts a transaction, steps the minimum tree one level per
// cycle, then commits the load update and the result.
// ----------------------------------------------------------------------------
module llba_ctrl
  import llba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_UPDATE
  } state_t;

  state_t           state_r, state_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.start  = in_valid && (state_r == ST_IDLE);
    cmd.reduce = (state_r == ST_REDUCE);
    cmd.update = (state_r == ST_UPDATE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_REDUCE;
          level_nxt = '0;
        end
      end
      ST_REDUCE: begin
        if (level_r == LAST_LEVEL) begin
          state_nxt = ST_UPDATE;
        end else begin
          level_nxt = level_r + LVL_W'(1);
        end
      end
      ST_UPDATE: begin
        if (cmd.update) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== src/llba_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llba_datapath
// Bin load registers, the registered minimum tree, the saturating adder
// and the result register.
// ----------------------------------------------------------------------------
module llba_datapath
  import llba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctl_cmd_t            cmd,
  input  wire in_item_t            in_data,
  input  wire logic                cfg_we,
  input  wire logic [ACTIVE_W-1:0] cfg_wdata,
  output out_item_t                out_data
);

  load_t               load_r [MAX_BINS];
  load_t               load_pad [TREE_SIZE];
  load_t               cand_val_r [TREE_SIZE];
  load_t               cand_val_nxt [TREE_SIZE];
  bin_idx_t            cand_idx_r [TREE_SIZE];
  bin_idx_t            cand_idx_nxt [TREE_SIZE];
  logic [TREE_SIZE-1:0] cand_ok_r, cand_ok_nxt;
  logic [SIZE_W-1:0]   size_r;
  logic [ACTIVE_W-1:0] active_bins_r;
  out_item_t           out_data_r;
  logic [LOAD_WIDTH:0] sum;
  logic                clear;
  logic                take_left;

  assign clear = cmd.start && in_data.new_batch;

  for (genvar g = 0; g < TREE_SIZE; g++) begin : g_pad
    if (g < MAX_BINS) begin : g_real
      assign load_pad[g] = load_r[g];
    end else begin : g_fill
      assign load_pad[g] = '0;
    end
  end

  always_comb begin
    take_left = 1'b0;
    for (int i = 0; i < TREE_SIZE; i++) begin
      cand_val_nxt[i] = cand_val_r[i];
      cand_idx_nxt[i] = cand_idx_r[i];
      cand_ok_nxt[i]  = cand_ok_r[i];
    end
    if (cmd.start) begin
      for (int i = 0; i < TREE_SIZE; i++) begin
        cand_val_nxt[i] = in_data.new_batch ? '0 : load_pad[i];
        cand_idx_nxt[i] = IDX_W'(i);
        cand_ok_nxt[i]  = (i < MAX_BINS) &&
                          ((i == 0) || (32'(i) < 32'(active_bins_r)));
      end
    end else if (cmd.reduce) begin
      for (int i = 0; i < TREE_SIZE / 2; i++) begin
        take_left = cand_ok_r[2*i] &&
                    (!cand_ok_r[2*i+1] || (cand_val_r[2*i] <= cand_val_r[2*i+1]));
        cand_val_nxt[i] = take_left ? cand_val_r[2*i] : cand_val_r[2*i+1];
        cand_idx_nxt[i] = take_left ? cand_idx_r[2*i] : cand_idx_r[2*i+1];
        cand_ok_nxt[i]  = cand_ok_r[2*i] || cand_ok_r[2*i+1];
      end
      for (int i = TREE_SIZE / 2; i < TREE_SIZE; i++) begin
        cand_ok_nxt[i] = 1'b0;
      end
    end
  end

  assign sum = {1'b0, cand_val_r[0]} + (LOAD_WIDTH + 1)'(size_r);

  always_ff @(posedge clk) begin
    for (int i = 0; i < TREE_SIZE; i++) begin
      cand_val_r[i] <= cand_val_nxt[i];
      cand_idx_r[i] <= cand_idx_nxt[i];
    end
    cand_ok_r <= cand_ok_nxt;
    if (cmd.start) begin
      size_r <= in_data.job_size;
    end
    if (cmd.update) begin
      out_data_r.bin_number     <= bin_num(cand_idx_r[0]);
      out_data_r.load_saturated <= sum[LOAD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BINS; i++) begin
        load_r[i] <= '0;
      end
      active_bins_r <= ACTIVE_RESET;
    end else begin
      if (clear) begin
        for (int i = 0; i < MAX_BINS; i++) begin
          load_r[i] <= '0;
        end
      end else if (cmd.update) begin
        load_r[cand_idx_r[0]] <= sum[LOAD_WIDTH] ? LOAD_MAX : sum[LOAD_WIDTH-1:0];
      end
      if (cfg_we) begin
        active_bins_r <= cfg_wdata;
      end
    end
  end

  assign out_data = out_data_r;

endmodule
`default_nettype wire

// ===== src/least_loaded_bin_assigner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_bin_assigner
// Greedy dispatcher that sends each job to the least loaded active bin.
// ----------------------------------------------------------------------------
// An accepted transaction loads the minimum tree, which resolves one level per cycle over the
// registered bin loads; the update then writes the result register. No new transaction is
// accepted until that update, as the block is busy through the reduction and the update.
// A new transaction is accepted while the previous result waits in the output register.
// Synchronous active-low reset clears all bin loads, sets active_bins to 16 and empties
// the output register.
module least_loaded_bin_assigner
  import llba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [ACTIVE_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;

  llba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  llba_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting a transaction");

  a_result_from_update : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid) && $past(rst_n)) |-> $past(cmd.update))
    else $error("result appeared without an update");

  a_bin_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.bin_number != '0))
    else $error("bin number zero on a valid result");

  a_no_update_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.update)
    else $error("update while the output register is held");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-loaded bin assigner testbench
// Drives job sizes through the valid/stall input channel and checks every
// result against a behavioral copy of the greedy least-loaded rule, or against
// the result typed into the directed table. That short table of jobs and bin
// counts comes first. Random jobs follow under several patterns of sender
// idling and receiver stalling, with the bin count changed between groups.
// ----------------------------------------------------------------------------
module testbench;
  import llba_pkg::*;

  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int SEGMENTS       = 6;
  localparam int SEGMENT_JOBS   = 60;
  localparam int MAX_REPORTS    = 40;
  localparam int PLAN_LEN       = 24;

  typedef struct {
    bit                  is_cfg;
    logic [ACTIVE_W-1:0] active;
    logic [SIZE_W-1:0]   size;
    logic                new_batch;
    bit                  pinned;
    logic [BIN_W-1:0]    bin;
    logic                sat;
  } plan_row_t;

  typedef struct {
    bit        pinned;
    out_item_t res;
  } pinned_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [ACTIVE_W-1:0] cfg_wdata = '0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  load_t               tracked_load [MAX_BINS];
  logic [ACTIVE_W-1:0] tracked_active;
  out_item_t           expected_bins [$];
  pinned_result_t      pinned_bins [$];

  // The bin count, the job size and the new-batch flag, with the result read
  // off directly where one is typed in.
  plan_row_t plan [PLAN_LEN] = '{
    '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, 5'd1, 1'b0},
    '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, 5'd2, 1'b0},
    '{1'b0, 5'd0,  16'h0001, 1'b0, 1'b1, 5'd2, 1'b0},
    '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, 5'd3, 1'b0},
    '{1'b0, 5'd0,  16'h8000, 1'b1, 1'b1, 5'd1, 1'b0},
    '{1'b0, 5'd0,  16'h7FFF, 1'b0, 1'b1, 5'd2, 1'b0},
    '{1'b0, 5'd0,  16'hAAAA, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b0, 5'd0,  16'h5555, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b1, 5'd1,  16'h0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b0, 5'd0,  16'h1234, 1'b0, 1'b1, 5'd1, 1'b0},
    '{1'b1, 5'd0,  16'h0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b0, 5'd0,  16'h00FF, 1'b0, 1'b1, 5'd1, 1'b0},
    '{1'b1, 5'd31, 16'h0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b0, 5'd0,  16'h0000, 1'b1, 1'b1, 5'd1, 1'b0},
    '{1'b0, 5'd0,  16'h0005, 1'b0, 1'b1, 5'd1, 1'b0},
    '{1'b0, 5'd0,  16'h0003, 1'b0, 1'b1, 5'd2, 1'b0},
    '{1'b1, 5'd2,  16'h0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b0, 5'd0,  16'h0100, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b1, 5'd17, 16'h0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b0, 5'd0,  16'hC3C3, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b1, 5'd16, 16'h0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{1'b0, 5'd0,  16'h0F0F, 1'b0, 1'b0, 5'd0, 1'b0}
  };

  least_loaded_bin_assigner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t assign_least_loaded(input in_item_t job);
    int unsigned used;
    int unsigned pick;
    int unsigned i;
    logic [LOAD_WIDTH:0] sum;
    out_item_t res;
    if (job.new_batch) begin
      foreach (tracked_load[k]) tracked_load[k] = '0;
    end
    used = tracked_active;
    if (used < 1) used = 1;
    if (used > MAX_BINS) used = MAX_BINS;
    pick = 0;
    for (i = 1; i < used; i++) begin
      if (tracked_load[i] < tracked_load[pick]) pick = i;
    end
    sum = {1'b0, tracked_load[pick]} + (LOAD_WIDTH + 1)'(job.job_size);
    res.load_saturated = sum[LOAD_WIDTH];
    tracked_load[pick] = sum[LOAD_WIDTH] ? LOAD_MAX : sum[LOAD_WIDTH-1:0];
    res.bin_number = BIN_W'(pick + 1);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_job(input logic [SIZE_W-1:0] size, input logic new_batch,
                          input bit pinned, input out_item_t res);
    pinned_result_t pin;
    pin.pinned = pinned;
    pin.res = res;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pinned_bins.push_back(pin);
    in_data <= '{job_size: size, new_batch: new_batch};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_job();
    logic [SIZE_W-1:0] size;
    logic              new_batch;
    case ($urandom_range(3))
      0: begin
        size = SIZE_W'($urandom);
      end
      1: begin
        size = SIZE_W'($urandom_range(255));
      end
      2: begin
        size = $urandom_range(1) ? '1 : '0;
      end
      default: begin
        size = SIZE_W'($urandom_range(16'hFFFF, 16'hF000));
      end
    endcase
    new_batch = ($urandom_range(19) == 0);
    send_job(size, new_batch, 1'b0, '0);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_bins.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input logic [ACTIVE_W-1:0] value);
    wait_until_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : scoreboard
    out_item_t      predicted;
    out_item_t      wanted;
    pinned_result_t pin;
    bit             moved;
    moved = 1'b0;
    if (!rst_n) begin
      foreach (tracked_load[k]) tracked_load[k] = '0;
      tracked_active = ACTIVE_RESET;
      quiet_cycles = 0;
    end else begin
      if (cfg_we) tracked_active = cfg_wdata;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        predicted = assign_least_loaded(in_data);
        pin.pinned = 1'b0;
        if (pinned_bins.size() != 0) pin = pinned_bins.pop_front();
        expected_bins.push_back(pin.pinned ? pin.res : predicted);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_bins.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, bin %0d", out_data.bin_number));
        end else begin
          wanted = expected_bins.pop_front();
          if (out_data.bin_number !== wanted.bin_number)
            report_mismatch($sformatf("bin_number %0d, wanted %0d",
                                      out_data.bin_number, wanted.bin_number));
          if (out_data.load_saturated !== wanted.load_saturated)
            report_mismatch($sformatf("load_saturated %0b, wanted %0b",
                                      out_data.load_saturated, wanted.load_saturated));
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d transactions outstanding", expected_bins.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned    phase;
    int unsigned    seg;
    out_item_t      typed_res;
    logic [ACTIVE_W-1:0] active;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        write_active(plan[r].active);
      end else begin
        typed_res.bin_number = plan[r].bin;
        typed_res.load_saturated = plan[r].sat;
        send_job(plan[r].size, plan[r].new_batch, plan[r].pinned, typed_res);
      end
    end

    write_active(ACTIVE_W'(3));
    repeat (20) send_random_job();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 85;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 85;
        end
        default: begin
          idle_pct = 13;
          stall_pct = 13;
        end
      endcase
      for (seg = 0; seg < SEGMENTS; seg++) begin
        case ($urandom_range(4))
          0: active = ACTIVE_W'(1);
          1: active = ACTIVE_W'(16);
          2: active = $urandom_range(1) ? ACTIVE_W'(0) : ACTIVE_W'(31);
          default: active = ACTIVE_W'($urandom_range(31));
        endcase
        write_active(active);
        repeat (SEGMENT_JOBS) send_random_job();
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
